@@ hdl/rrp_pkg.sv @@
`default_nettype none

package rrp_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_HDR  = 2'd1,
    KIND_END  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ET_SIMPLE = 3'd0,
    ET_ERROR  = 3'd1,
    ET_INT    = 3'd2,
    ET_BULK   = 3'd3,
    ET_ARRAY  = 3'd4
  } elem_type_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SERVER    = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_TERM  = 3'd4,
    ST_LINE_LONG = 3'd5,
    ST_TOO_DEEP  = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_LINE = 3'd1,
    PH_LEN  = 3'd2,
    PH_BULK = 3'd3,
    PH_BCR  = 3'd4,
    PH_BLF  = 3'd5,
    PH_HALT = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  elem_type;
    logic        is_nil;
    logic [3:0]  nest_depth;
    logic [31:0] elem_index;
    logic [31:0] elem_length;
    logic        reply_done;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // Request from the parser to the array stack
  typedef struct packed {
    logic        push;
    logic        pop;
    logic [31:0] len;
  } stk_cmd_t;

  // What the stack shows to the parser
  typedef struct packed {
    logic        full;
    logic        last_elem;
    logic [31:0] cur_idx;
  } stk_stat_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                  input logic [2:0] et, input logic nil,
                                  input logic [3:0] depth, input logic [31:0] idx,
                                  input logic [31:0] len, input logic done,
                                  input logic [2:0] st);
    res_t r;
    r.kind        = kind;
    r.data_byte   = data;
    r.elem_type   = et;
    r.is_nil      = nil;
    r.nest_depth  = depth;
    r.elem_index  = idx;
    r.elem_length = len;
    r.reply_done  = done;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rrp_rx_if.sv @@
`default_nettype none

interface rrp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/rrp_tx_if.sv @@
`default_nettype none

interface rrp_tx_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [2:0]  elem_type;
  logic        is_nil;
  logic [3:0]  nest_depth;
  logic [31:0] elem_index;
  logic [31:0] elem_length;
  logic        reply_done;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output kind, output data_byte, output elem_type,
                  output is_nil, output nest_depth, output elem_index,
                  output elem_length, output reply_done, output status,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input elem_type,
                input is_nil, input nest_depth, input elem_index,
                input elem_length, input reply_done, input status,
                input last, output ready);
endinterface

`default_nettype wire

@@ hdl/rrp_stack.sv @@
`default_nettype none

module rrp_stack import rrp_pkg::*; #(
  parameter int MAX_DEPTH = 8,
  parameter int LVW       = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire stk_cmd_t       cmd,
  output logic [LVW-1:0]      level,
  output stk_stat_t           stat
);

  // One lane per open array: current child index and children still to come
  logic [31:0]    idx_q [MAX_DEPTH];
  logic [31:0]    rem_q [MAX_DEPTH];
  logic [LVW-1:0] level_next;
  logic [LVW-1:0] tgt;
  logic           found;

  always_comb begin
    stat.cur_idx = 32'd0;
    tgt          = '0;
    found        = 1'b0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (level == LVW'(i + 1)) begin
        stat.cur_idx = idx_q[i];
      end
      // highest open level that still has a child to come
      if (LVW'(i) < level && rem_q[i] != 32'd0) begin
        found = 1'b1;
        tgt   = LVW'(i + 1);
      end
    end
    stat.full      = (level >= LVW'(MAX_DEPTH));
    stat.last_elem = !found;
  end

  always_comb begin
    level_next = level;
    if (cmd.push) begin
      level_next = level + LVW'(1);
    end else if (cmd.pop) begin
      level_next = found ? tgt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (cmd.push && level == LVW'(i)) begin
        idx_q[i] <= 32'd1;
        rem_q[i] <= cmd.len - 32'd1;
      end else if (cmd.pop && found && tgt == LVW'(i + 1)) begin
        idx_q[i] <= idx_q[i] + 32'd1;
        rem_q[i] <= rem_q[i] - 32'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/rrp_core.sv @@
`default_nettype none

module rrp_core import rrp_pkg::*; #(
  parameter int MAX_DEPTH  = 8,
  parameter int LINE_LIMIT = 256,
  parameter int LVW        = $clog2(MAX_DEPTH + 1),
  parameter int LCW        = $clog2(LINE_LIMIT)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire logic [7:0]     rx_byte,
  input  wire logic [LVW-1:0] level,
  input  wire stk_stat_t      stat,
  output stk_cmd_t            cmd,
  output logic [1:0]          n_res,
  output res_t                res0,
  output res_t                res1
);

  phase_t         phase, phase_next;
  logic           held_cr, held_cr_next;
  logic [LCW-1:0] line_count, line_count_next;
  logic [31:0]    length_accum, length_accum_next;
  logic           length_negative, length_negative_next;
  logic           number_ended, number_ended_next;
  logic [31:0]    bulk_remaining, bulk_remaining_next;
  logic [2:0]     current_type, current_type_next;

  logic           ll_hit, is_cr, is_lf, is_digit, is_line_type, is_len_type;
  logic           no_digits, ovf, neg_bad;
  logic [35:0]    acc_mul;
  logic [2:0]     byte_type;
  logic [3:0]     depth;
  logic [31:0]    idx;
  logic [1:0]     n_raw;
  res_t           r0, r1;

  // Byte decode shared by next-state and output logic
  always_comb begin
    ll_hit       = (line_count >= LCW'(LINE_LIMIT - 1));
    is_cr        = (rx_byte == CH_CR);
    is_lf        = (rx_byte == CH_LF);
    is_digit     = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    is_line_type = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS) || (rx_byte == CH_COLON);
    is_len_type  = (rx_byte == CH_DOLLAR) || (rx_byte == CH_STAR);
    case (rx_byte)
      CH_PLUS:   byte_type = ET_SIMPLE;
      CH_MINUS:  byte_type = ET_ERROR;
      CH_COLON:  byte_type = ET_INT;
      CH_DOLLAR: byte_type = ET_BULK;
      default:   byte_type = ET_ARRAY;
    endcase
    no_digits = (line_count == LCW'(length_negative));
    acc_mul   = ({4'd0, length_accum} << 3) + ({4'd0, length_accum} << 1)
              + {28'd0, rx_byte - CH_ZERO};
    ovf       = (acc_mul[35:32] != 4'd0);
    neg_bad   = (length_accum != 32'd1);
    depth     = 4'(level);
    idx       = stat.cur_idx;
  end

  // Next state
  always_comb begin
    phase_next           = phase;
    held_cr_next         = held_cr;
    line_count_next      = line_count;
    length_accum_next    = length_accum;
    length_negative_next = length_negative;
    number_ended_next    = number_ended;
    bulk_remaining_next  = bulk_remaining;
    current_type_next    = current_type;
    case (phase)
      PH_TYPE: begin
        held_cr_next         = 1'b0;
        line_count_next      = '0;
        length_accum_next    = 32'd0;
        length_negative_next = 1'b0;
        number_ended_next    = 1'b0;
        if (is_line_type) begin
          current_type_next = byte_type;
          phase_next        = PH_LINE;
        end else if (is_len_type) begin
          current_type_next = byte_type;
          phase_next        = PH_LEN;
        end else begin
          phase_next = PH_HALT;
        end
      end
      PH_LINE: begin
        if (ll_hit) begin
          phase_next = PH_HALT;
        end else begin
          line_count_next = line_count + LCW'(1);
          if (held_cr && is_lf) begin
            held_cr_next    = 1'b0;
            line_count_next = '0;
            phase_next      = (current_type == ET_ERROR) ? PH_HALT : PH_TYPE;
          end else begin
            held_cr_next = is_cr;
          end
        end
      end
      PH_LEN: begin
        if (ll_hit) begin
          phase_next = PH_HALT;
        end else begin
          line_count_next = line_count + LCW'(1);
          if (!number_ended) begin
            if (is_cr) begin
              if (no_digits) begin
                phase_next = PH_HALT;
              end else begin
                number_ended_next = 1'b1;
              end
            end else if (rx_byte == CH_MINUS && line_count == '0) begin
              length_negative_next = 1'b1;
            end else if (is_digit) begin
              if (ovf) begin
                phase_next = PH_HALT;
              end else begin
                length_accum_next = acc_mul[31:0];
              end
            end else begin
              phase_next = PH_HALT;
            end
          end else if (!is_lf || (length_negative && neg_bad)) begin
            phase_next = PH_HALT;
          end else if (!length_negative && current_type == ET_BULK) begin
            bulk_remaining_next = length_accum;
            phase_next          = (length_accum == 32'd0) ? PH_BCR : PH_BULK;
          end else if (!length_negative && length_accum != 32'd0 && stat.full) begin
            phase_next = PH_HALT;
          end else begin
            phase_next = PH_TYPE;
          end
          if (number_ended && phase_next != PH_HALT) begin
            held_cr_next         = 1'b0;
            line_count_next      = '0;
            length_accum_next    = 32'd0;
            length_negative_next = 1'b0;
            number_ended_next    = 1'b0;
          end
        end
      end
      PH_BULK: begin
        bulk_remaining_next = bulk_remaining - 32'd1;
        if (bulk_remaining == 32'd1) begin
          phase_next = PH_BCR;
        end
      end
      PH_BCR: begin
        phase_next = is_cr ? PH_BLF : PH_HALT;
      end
      PH_BLF: begin
        phase_next = is_lf ? PH_TYPE : PH_HALT;
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  // Results and stack requests
  always_comb begin
    n_raw   = 2'd0;
    r0      = mk_res(KIND_DATA, 8'd0, current_type, 1'b0, depth, idx, 32'd0, 1'b0, ST_OK);
    r1      = r0;
    cmd     = '0;
    cmd.len = length_accum;
    case (phase)
      PH_TYPE: begin
        if (is_line_type) begin
          r0    = mk_res(KIND_HDR, 8'd0, byte_type, 1'b0, depth, idx, 32'd0, 1'b0, ST_OK);
          n_raw = 2'd1;
        end else if (!is_len_type) begin
          r0    = mk_res(KIND_ERR, 8'd0, ET_SIMPLE, 1'b0, depth, idx, 32'd0, 1'b0,
                         ST_BAD_TYPE);
          n_raw = 2'd1;
        end
      end
      PH_LINE: begin
        if (ll_hit) begin
          r0.kind   = KIND_ERR;
          r0.status = ST_LINE_LONG;
          n_raw     = 2'd1;
        end else if (held_cr && is_lf) begin
          r0.kind       = KIND_END;
          r0.reply_done = stat.last_elem;
          r0.status     = (current_type == ET_ERROR) ? ST_SERVER : ST_OK;
          cmd.pop       = 1'b1;
          n_raw         = 2'd1;
        end else if (held_cr) begin
          // release the held CR ahead of this byte
          r0.data_byte = CH_CR;
          r1.data_byte = rx_byte;
          n_raw        = is_cr ? 2'd1 : 2'd2;
        end else if (!is_cr) begin
          r0.data_byte = rx_byte;
          n_raw        = 2'd1;
        end
      end
      PH_LEN: begin
        if (ll_hit) begin
          r0.kind   = KIND_ERR;
          r0.status = ST_LINE_LONG;
          n_raw     = 2'd1;
        end else if (!number_ended) begin
          if (is_cr) begin
            if (no_digits) begin
              r0.kind   = KIND_ERR;
              r0.status = ST_BAD_LEN;
              n_raw     = 2'd1;
            end
          end else if (rx_byte == CH_MINUS && line_count == '0) begin
            n_raw = 2'd0;
          end else if (is_digit) begin
            if (ovf) begin
              r0.kind   = KIND_ERR;
              r0.status = ST_OVERFLOW;
              n_raw     = 2'd1;
            end
          end else begin
            r0.kind   = KIND_ERR;
            r0.status = ST_BAD_LEN;
            n_raw     = 2'd1;
          end
        end else if (!is_lf) begin
          r0.kind   = KIND_ERR;
          r0.status = ST_BAD_TERM;
          n_raw     = 2'd1;
        end else if (length_negative) begin
          if (neg_bad) begin
            r0.kind   = KIND_ERR;
            r0.status = ST_BAD_LEN;
            n_raw     = 2'd1;
          end else begin
            r0.kind       = KIND_HDR;
            r0.is_nil     = 1'b1;
            r1.kind       = KIND_END;
            r1.reply_done = stat.last_elem;
            cmd.pop       = 1'b1;
            n_raw         = 2'd2;
          end
        end else if (current_type == ET_BULK) begin
          r0.kind        = KIND_HDR;
          r0.elem_length = length_accum;
          n_raw          = 2'd1;
        end else if (length_accum == 32'd0) begin
          r0.kind       = KIND_HDR;
          r1.kind       = KIND_END;
          r1.reply_done = stat.last_elem;
          cmd.pop       = 1'b1;
          n_raw         = 2'd2;
        end else if (stat.full) begin
          r0.kind   = KIND_ERR;
          r0.status = ST_TOO_DEEP;
          n_raw     = 2'd1;
        end else begin
          r0.kind        = KIND_HDR;
          r0.elem_length = length_accum;
          cmd.push       = 1'b1;
          n_raw          = 2'd1;
        end
      end
      PH_BULK: begin
        r0.data_byte = rx_byte;
        n_raw        = 2'd1;
      end
      PH_BCR: begin
        if (!is_cr) begin
          r0.kind   = KIND_ERR;
          r0.status = ST_BAD_TERM;
          n_raw     = 2'd1;
        end
      end
      PH_BLF: begin
        if (!is_lf) begin
          r0.kind   = KIND_ERR;
          r0.status = ST_BAD_TERM;
        end else begin
          r0.kind       = KIND_END;
          r0.reply_done = stat.last_elem;
          cmd.pop       = 1'b1;
        end
        n_raw = 2'd1;
      end
      default: begin
        n_raw = 2'd0;
      end
    endcase
    r0.last  = (n_raw == 2'd1);
    r1.last  = (n_raw == 2'd2);
    cmd.push = cmd.push && take;
    cmd.pop  = cmd.pop && take;
    n_res    = take ? n_raw : 2'd0;
    res0     = r0;
    res1     = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TYPE;
      held_cr         <= 1'b0;
      line_count      <= '0;
      length_accum    <= 32'd0;
      length_negative <= 1'b0;
      number_ended    <= 1'b0;
      bulk_remaining  <= 32'd0;
      current_type    <= ET_SIMPLE;
    end else if (take) begin
      phase           <= phase_next;
      held_cr         <= held_cr_next;
      line_count      <= line_count_next;
      length_accum    <= length_accum_next;
      length_negative <= length_negative_next;
      number_ended    <= number_ended_next;
      bulk_remaining  <= bulk_remaining_next;
      current_type    <= current_type_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rrp_res_fifo.sv @@
`default_nettype none

module rrp_res_fifo import rrp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic [1:0] n_res,
  input  wire res_t      res0,
  input  wire res_t      res1,
  output logic           space,
  rrp_tx_if.source       tx
);

  res_t       buf_q [4];
  logic [1:0] head, tail;
  logic [2:0] count, count_left;
  logic       pop;
  res_t       hd;

  assign pop        = tx.valid && tx.ready;
  assign count_left = count - {2'd0, pop};
  // room for the two results a byte can cause
  assign space      = (count_left <= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 3'd0;
    end else begin
      head  <= head + {1'b0, pop};
      tail  <= tail + n_res;
      count <= count_left + {1'b0, n_res};
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      buf_q[tail] <= res0;
    end
    if (n_res == 2'd2) begin
      buf_q[tail + 2'd1] <= res1;
    end
  end

  assign hd             = buf_q[head];
  assign tx.valid       = (count != 3'd0);
  assign tx.kind        = hd.kind;
  assign tx.data_byte   = hd.data_byte;
  assign tx.elem_type   = hd.elem_type;
  assign tx.is_nil      = hd.is_nil;
  assign tx.nest_depth  = hd.nest_depth;
  assign tx.elem_index  = hd.elem_index;
  assign tx.elem_length = hd.elem_length;
  assign tx.reply_done  = hd.reply_done;
  assign tx.status      = hd.status;
  assign tx.last        = hd.last;

endmodule

`default_nettype wire

@@ hdl/resp_reply_parser.sv @@
// Channel  Dir  Transaction payload
// -------  ---  ----------------------------------------------------------------
// rx       in   rx_byte: one byte of the reply stream
// tx       out  kind, data_byte, elem_type, is_nil, nest_depth, elem_index,
//               elem_length, reply_done, status, last
//
// One byte is parsed per cycle while the queue has room: an input register feeds
// the parser, whose results go into a four-entry result queue. A byte causes
// zero, one or two results; the tx port drains one per cycle while tx is ready,
// so bytes that cause two results set the long-run rate. rst is synchronous and
// clears the parser, the stack depth and the queue. rx stalls only when the queue
// cannot hold two more results.
`default_nettype none

module resp_reply_parser import rrp_pkg::*; #(
  parameter int MAX_DEPTH  = 8,
  parameter int LINE_LIMIT = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  rrp_rx_if.sink    rx,
  rrp_tx_if.source  tx
);

  localparam int LVW = $clog2(MAX_DEPTH + 1);
  localparam int LCW = $clog2(LINE_LIMIT);

  logic           in_full;
  logic [7:0]     in_byte;
  logic           take;
  logic           space;
  logic [1:0]     n_res;
  res_t           res0, res1;
  stk_cmd_t       cmd;
  stk_stat_t      stat;
  logic [LVW-1:0] level;

  assign take     = in_full && space;
  assign rx.ready = !in_full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx.ready) begin
      in_full <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  rrp_core #(
    .MAX_DEPTH (MAX_DEPTH),
    .LINE_LIMIT(LINE_LIMIT),
    .LVW       (LVW),
    .LCW       (LCW)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .rx_byte(in_byte),
    .level  (level),
    .stat   (stat),
    .cmd    (cmd),
    .n_res  (n_res),
    .res0   (res0),
    .res1   (res1)
  );

  rrp_stack #(
    .MAX_DEPTH(MAX_DEPTH),
    .LVW      (LVW)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .level(level),
    .stat (stat)
  );

  rrp_res_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .n_res(n_res),
    .res0 (res0),
    .res1 (res1),
    .space(space),
    .tx   (tx)
  );

endmodule

`default_nettype wire

@@ hdl/rrp_checker.sv @@
`default_nettype none

module rrp_checker import rrp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        tx_valid,
  input wire logic        tx_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  data_byte,
  input wire logic        is_nil,
  input wire logic [31:0] elem_length,
  input wire logic        reply_done,
  input wire logic [2:0]  status,
  input wire logic        last
);

  // a stalled transaction holds
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(kind) && $stable(data_byte)
      && $stable(status))
    else $error("tx transaction changed while stalled");

  // nothing follows a failure or a server error
  a_halt: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_ready && (kind == KIND_ERR || status == ST_SERVER) |=> !tx_valid)
    else $error("result after halt");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    tx_valid && kind == KIND_DATA |-> status == ST_OK && !reply_done && !is_nil)
    else $error("payload byte with status or done mark");

  // the done mark sits only on an element end that is the last result of its byte
  a_done: assert property (@(posedge clk) disable iff (rst)
    tx_valid && reply_done |-> kind == KIND_END && last)
    else $error("done mark off an element end");

  a_nil: assert property (@(posedge clk) disable iff (rst)
    tx_valid && is_nil |-> kind == KIND_HDR && elem_length == 32'd0 && !last)
    else $error("nil flag off a header or without its end");

endmodule

bind resp_reply_parser rrp_checker u_rrp_checker (
  .clk        (clk),
  .rst        (rst),
  .tx_valid   (tx.valid),
  .tx_ready   (tx.ready),
  .kind       (tx.kind),
  .data_byte  (tx.data_byte),
  .is_nil     (tx.is_nil),
  .elem_length(tx.elem_length),
  .reply_done (tx.reply_done),
  .status     (tx.status),
  .last       (tx.last)
);

`default_nettype wire
